// File: hw/rtl/satok_pkg.sv
// Shared types, character codes and error codes for the shell argument tokenizer.
package satok_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic [7:0] MAX_ARGS_RESET = 8'd16;

    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_USER_W  = 2;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_QUOTE    = 2'd1,
        ERR_OVERFLOW = 2'd2,
        ERR_DANGLING = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic [7:0] next_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       token_end;
        logic [7:0] arg_index;
        logic       line_done;
        err_code_t  error_code;
    } result_t;

endpackage

// File: hw/rtl/satok_in_stage.sv
// Input register stage: holds one accepted character item.
module satok_in_stage
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  satok_pkg::in_item_t        in_item,
    input  logic                       take,
    output logic                       item_valid,
    output satok_pkg::in_item_t        item
);

    logic                valid_reg;
    logic                valid_next;
    satok_pkg::in_item_t item_reg;

    // free when empty or the held item is consumed this cycle
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: hw/rtl/satok_core.sv
// Tokenizer state and the per-character step logic.
module satok_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_value,
    input  logic                  step,
    input  satok_pkg::in_item_t   item,
    output satok_pkg::result_t    result
);

    logic [7:0] max_args_reg;
    logic       tok_reg,   tok_next;
    logic       quote_reg, quote_next;
    logic       esc_reg,   esc_next;
    logic       dq_reg,    dq_next;
    logic [7:0] cnt_reg,   cnt_next;
    logic       halt_reg,  halt_next;

    always_comb
    begin
        logic [7:0]           c;
        logic [7:0]           qch;
        logic                 add;
        logic                 fin;
        logic                 tend;
        logic                 done;
        logic                 clr;
        satok_pkg::err_code_t err;

        c          = item.char_in;
        qch        = dq_reg ? satok_pkg::CH_DQ : satok_pkg::CH_SQ;
        add        = 1'b0;
        fin        = 1'b0;
        tend       = 1'b0;
        done       = 1'b0;
        clr        = 1'b0;
        err        = satok_pkg::ERR_NONE;
        tok_next   = tok_reg;
        quote_next = quote_reg;
        esc_next   = esc_reg;
        dq_next    = dq_reg;
        cnt_next   = cnt_reg;
        halt_next  = halt_reg;

        if (halt_reg)
        begin
            // skip to the terminator, which clears the line quietly
            clr = (c == satok_pkg::CH_NUL);
        end
        else
        begin
            if (c inside {satok_pkg::CH_SPACE, satok_pkg::CH_TAB,
                          satok_pkg::CH_NL, satok_pkg::CH_NUL})
            begin
                if (tok_reg)
                begin
                    if (quote_reg)
                    begin
                        add = 1'b1;
                    end
                    else if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        add      = 1'b1;
                    end
                    else
                    begin
                        tok_next = 1'b0;
                        fin      = 1'b1;
                    end
                end
            end
            else if (c inside {satok_pkg::CH_SQ, satok_pkg::CH_DQ})
            begin
                if (esc_reg)
                begin
                    tok_next = 1'b1;
                    add      = 1'b1;
                    esc_next = 1'b0;
                end
                else if (!tok_reg)
                begin
                    tok_next   = 1'b1;
                    quote_next = 1'b1;
                    dq_next    = (c == satok_pkg::CH_DQ);
                end
                else if (quote_reg)
                begin
                    if (c == qch)
                    begin
                        quote_next = 1'b0;
                        tok_next   = 1'b0;
                        fin        = 1'b1;
                    end
                    else
                    begin
                        add = 1'b1;
                    end
                end
                else
                begin
                    err = satok_pkg::ERR_QUOTE;   // stray quote in bare token
                end
            end
            else if (c == satok_pkg::CH_BSL)
            begin
                if (quote_reg && (item.next_char != qch))
                begin
                    add = 1'b1;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    tok_next = 1'b1;
                    add      = 1'b1;
                end
                else
                begin
                    esc_next = 1'b1;
                    tok_next = 1'b1;
                end
            end
            else
            begin
                esc_next = 1'b0;
                tok_next = 1'b1;
                add      = 1'b1;
            end

            if ((err == satok_pkg::ERR_NONE) && fin)
            begin
                if (cnt_reg == max_args_reg)
                begin
                    err = satok_pkg::ERR_OVERFLOW;
                end
                else
                begin
                    tend     = 1'b1;
                    cnt_next = cnt_reg + 8'd1;
                end
            end

            if (c == satok_pkg::CH_NUL)
            begin
                add  = 1'b0;
                done = 1'b1;
                clr  = 1'b1;
                if (err == satok_pkg::ERR_NONE)
                begin
                    if (quote_next)
                    begin
                        err = satok_pkg::ERR_QUOTE;
                    end
                    else if (esc_next || tok_next)
                    begin
                        err = satok_pkg::ERR_DANGLING;
                    end
                end
            end
            else if (err != satok_pkg::ERR_NONE)
            begin
                done      = 1'b1;
                halt_next = 1'b1;
                add       = 1'b0;
                tend      = 1'b0;
            end
        end

        if (clr)
        begin
            tok_next   = 1'b0;
            quote_next = 1'b0;
            esc_next   = 1'b0;
            dq_next    = 1'b0;
            cnt_next   = 8'd0;
            halt_next  = 1'b0;
        end

        // index is always the count before this character
        result.char_out   = add ? c : 8'd0;
        result.char_valid = add;
        result.token_end  = tend;
        result.arg_index  = cnt_reg;
        result.line_done  = done;
        result.error_code = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg <= satok_pkg::MAX_ARGS_RESET;
        end
        else if (cfg_we)
        begin
            max_args_reg <= cfg_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= 1'b0;
            quote_reg <= 1'b0;
            esc_reg   <= 1'b0;
            dq_reg    <= 1'b0;
            cnt_reg   <= 8'd0;
            halt_reg  <= 1'b0;
        end
        else if (step)
        begin
            tok_reg   <= tok_next;
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            dq_reg    <= dq_next;
            cnt_reg   <= cnt_next;
            halt_reg  <= halt_next;
        end
    end

endmodule

// File: hw/rtl/satok_out_stage.sv
// Result register stage driving the output stream.
module satok_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  satok_pkg::result_t  result,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output satok_pkg::result_t  out_item
);

    logic               valid_reg;
    logic               valid_next;
    satok_pkg::result_t item_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

endmodule

// File: hw/rtl/shell_argument_tokenizer.sv
// Top level of the shell-style argument tokenizer.
//
// Splits a command line into arguments, one character per item, the way a
// shell does: blanks (space, tab, newline) separate arguments, single or
// double quotes group text, and a backslash escapes the next character
// (inside quotes it escapes only the closing quote, looked ahead through
// next_char). Each character gives exactly one result item: the character
// to append to the current argument (flagged by char_valid), a token-end
// mark with the completed argument's index, and on the zero terminator or
// an error a line-done mark with an error code. After an error the block
// swallows characters until the terminator, which clears the line state.
// Throughput is one item per clock while the result side does not stall:
// an item is held in the input register, the step logic reads it and the
// tokenizer state together, and the result is registered in the output
// register, from which it leaves on the result stream. A stall on the
// result side holds the output register; the input register still takes
// one item if it is empty, and once both are full s_tready follows
// m_tready in the same cycle.
// max_args (reset 16) is written through the cfg port; cfg_ready is always
// high, and writes belong between lines while the block is idle.
module shell_argument_tokenizer
(
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [satok_pkg::IN_DATA_W-1:0]  s_tdata,   // char_in[7:0], next_char[15:8]
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [satok_pkg::OUT_DATA_W-1:0] m_tdata,   // char_out[7:0], arg_index[15:8],
                                                        // error_code[17:16], zero[23:18]
    output logic [satok_pkg::OUT_USER_W-1:0] m_tuser,   // char_valid[0], token_end[1]
    output logic                             m_tlast,   // line_done
    // max_args write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [7:0]                       cfg_data
);

    satok_pkg::in_item_t in_item;
    satok_pkg::in_item_t held_item;
    satok_pkg::result_t  step_result;
    satok_pkg::result_t  out_item;
    logic                held_valid;
    logic                out_free;
    logic                step;

    assign in_item.char_in   = s_tdata[7:0];
    assign in_item.next_char = s_tdata[15:8];

    // process the held character whenever the result register can take it
    assign step      = held_valid && out_free;
    assign cfg_ready = 1'b1;

    satok_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (step),
        .item_valid (held_valid),
        .item       (held_item)
    );

    satok_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_value (cfg_data),
        .step      (step),
        .item      (held_item),
        .result    (step_result)
    );

    satok_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .result    (step_result),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {6'd0, out_item.error_code, out_item.arg_index, out_item.char_out};
    assign m_tuser = {out_item.token_end, out_item.char_valid};
    assign m_tlast = out_item.line_done;

endmodule
